// ===== design/assert_macros.svh =====
// Assertion macros used by the top-level design file.
// Needs nothing beyond the language itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/wvp_pkg.sv =====
// Constants, word types and the arctangent table of the waypoint view projection.
// Has no dependencies; the rotation, vectoring and top-level design files import it.
package wvp_pkg;

   localparam int AW = 34;
   localparam int CW = 34;
   localparam int XW = 62;
   localparam int PW = AW + CW - 30;
   localparam int ROT_LANES = 2;

   localparam logic signed [AW-1:0] Q29_PI      = 34'sd1686629713;
   localparam logic signed [AW-1:0] Q29_TWO_PI  = 34'sd3373259426;
   localparam logic signed [AW-1:0] Q29_HALF_PI = 34'sd843314857;
   localparam logic signed [AW-1:0] Q29_QTR_PI  = 34'sd421657428;
   localparam logic signed [CW-1:0] Q30_GAIN    = 34'sd652032874;
   localparam logic [29:0]          Q30_GAIN_U  = 30'd652032874;
   localparam logic [32:0]          EARTH_RADIUS_MM = 33'd6371000000;

   typedef struct packed {
      logic signed [31:0] dlat_d;
      logic signed [32:0] dlon_d;
      logic signed [32:0] dalt_d;
      logic signed [31:0] yaw;
      logic signed [31:0] pitch;
      logic [15:0]        tag;
   } rot_side_type;

   typedef struct packed {
      logic signed [CW-1:0] cos_roll;
      logic signed [CW-1:0] sin_roll;
      logic signed [32:0]   dalt_d;
      logic signed [31:0]   yaw;
      logic signed [31:0]   pitch;
      logic [15:0]          tag;
   } vec_side_type;

   typedef struct packed {
      logic signed [AW-1:0] bearing;
      vec_side_type         base;
   } mid_type;

   typedef struct packed {
      logic signed [AW-1:0] bearing;
      logic signed [CW-1:0] cos_roll;
      logic signed [CW-1:0] sin_roll;
      logic signed [31:0]   yaw;
      logic signed [31:0]   pitch;
      logic [15:0]          tag;
      logic                 dist_zero;
      logic                 dalt_pos;
      logic                 dalt_neg;
   } elev_side_type;

   // Arctangent of 2^-idx in Q4.29, summed as a series in Q60 and rounded.
   function automatic logic signed [AW-1:0] atan_rom(input int unsigned idx);
      logic signed [63:0] sum;
      logic [63:0]        num;
      int unsigned        e;
      sum = '0;
      if (idx == 0) begin
         return Q29_QTR_PI;
      end
      for (int unsigned k = 0; k < 64; k++) begin
         e = idx * (2 * k + 1);
         if (e > 60) begin
            break;
         end
         num = (64'd1 << (60 - e)) / 64'(2 * k + 1);
         if (k[0]) begin
            sum = sum - $signed(num);
         end else begin
            sum = sum + $signed(num);
         end
      end
      return AW'((sum + (64'sd1 <<< 30)) >>> 31);
   endfunction

endpackage

// ===== design/wvp_ifs.sv =====
// Request and response channel interfaces of the waypoint view projection.
// Has no dependencies.
interface wvp_req_if;
   logic               valid;
   logic               ready;
   logic signed [30:0] waypoint_lat;
   logic signed [31:0] waypoint_lon;
   logic signed [31:0] waypoint_alt;
   logic signed [30:0] own_lat;
   logic signed [31:0] own_lon;
   logic signed [31:0] own_alt;
   logic signed [31:0] yaw_angle;
   logic signed [31:0] pitch_angle;
   logic signed [31:0] roll_angle;
   logic [15:0]        waypoint_tag;
   modport source (output valid, waypoint_lat, waypoint_lon, waypoint_alt, own_lat, own_lon,
                   own_alt, yaw_angle, pitch_angle, roll_angle, waypoint_tag, input ready);
   modport sink (input valid, waypoint_lat, waypoint_lon, waypoint_alt, own_lat, own_lon,
                 own_alt, yaw_angle, pitch_angle, roll_angle, waypoint_tag, output ready);
endinterface

interface wvp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] screen_x;
   logic signed [31:0] screen_y;
   logic [15:0]        tag_out;
   modport source (output valid, screen_x, screen_y, tag_out, input ready);
   modport sink (input valid, screen_x, screen_y, tag_out, output ready);
endinterface

// ===== design/wvp_rotate.sv =====
// Pipelined rotation CORDIC giving cosine and sine of several angles side by side.
// Depends on wvp_pkg.
module wvp_rotate import wvp_pkg::*; #(
   parameter int STAGES = 24,
   parameter int SIDE_W = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 in_valid,
   input  logic signed [31:0]   in_angle [ROT_LANES],
   input  logic [SIDE_W-1:0]    in_side,
   output logic                 out_valid,
   output logic signed [CW-1:0] out_cos [ROT_LANES],
   output logic signed [CW-1:0] out_sin [ROT_LANES],
   output logic [SIDE_W-1:0]    out_side
);

   logic signed [AW-1:0] atan_c [STAGES];
   logic signed [AW-1:0] z_in [ROT_LANES];
   logic                 neg_in [ROT_LANES];
   logic [STAGES+1:0]    valid_ff;
   logic [SIDE_W-1:0]    side_ff [STAGES+2];
   logic signed [CW-1:0] x_ff [STAGES+1][ROT_LANES];
   logic signed [CW-1:0] y_ff [STAGES+1][ROT_LANES];
   logic signed [AW-1:0] z_ff [STAGES+1][ROT_LANES];
   logic                 neg_ff [STAGES+1][ROT_LANES];
   logic signed [CW-1:0] cos_ff [ROT_LANES];
   logic signed [CW-1:0] sin_ff [ROT_LANES];

   for (genvar g = 0; g < STAGES; g++) begin : g_atan
      assign atan_c[g] = atan_rom(g);
   end

   // Bring the angle into [-pi, pi], then fold it into [-pi/2, pi/2].
   always_comb begin
      logic signed [AW-1:0] r;
      r = '0;
      for (int l = 0; l < ROT_LANES; l++) begin
         r = AW'(in_angle[l]);
         if (r > Q29_PI) begin
            r = r - Q29_TWO_PI;
         end else if (r < -Q29_PI) begin
            r = r + Q29_TWO_PI;
         end
         z_in[l] = r;
         neg_in[l] = 1'b0;
         if (r > Q29_HALF_PI) begin
            z_in[l] = r - Q29_PI;
            neg_in[l] = 1'b1;
         end else if (r < -Q29_HALF_PI) begin
            z_in[l] = r + Q29_PI;
            neg_in[l] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[STAGES:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= in_side;
         for (int s = 0; s < STAGES + 1; s++) begin
            side_ff[s+1] <= side_ff[s];
         end
         for (int l = 0; l < ROT_LANES; l++) begin
            x_ff[0][l]   <= Q30_GAIN;
            y_ff[0][l]   <= '0;
            z_ff[0][l]   <= z_in[l];
            neg_ff[0][l] <= neg_in[l];
            for (int s = 0; s < STAGES; s++) begin
               if (z_ff[s][l] >= 0) begin
                  x_ff[s+1][l] <= x_ff[s][l] - (y_ff[s][l] >>> s);
                  y_ff[s+1][l] <= y_ff[s][l] + (x_ff[s][l] >>> s);
                  z_ff[s+1][l] <= z_ff[s][l] - atan_c[s];
               end else begin
                  x_ff[s+1][l] <= x_ff[s][l] + (y_ff[s][l] >>> s);
                  y_ff[s+1][l] <= y_ff[s][l] - (x_ff[s][l] >>> s);
                  z_ff[s+1][l] <= z_ff[s][l] + atan_c[s];
               end
               neg_ff[s+1][l] <= neg_ff[s][l];
            end
            cos_ff[l] <= neg_ff[STAGES][l] ? -x_ff[STAGES][l] : x_ff[STAGES][l];
            sin_ff[l] <= neg_ff[STAGES][l] ? -y_ff[STAGES][l] : y_ff[STAGES][l];
         end
      end
   end

   assign out_valid = valid_ff[STAGES+1];
   assign out_side  = side_ff[STAGES+1];
   assign out_cos   = cos_ff;
   assign out_sin   = sin_ff;

endmodule

// ===== design/wvp_vector.sv =====
// Pipelined vectoring CORDIC giving the angle and the scaled magnitude of a vector.
// Depends on wvp_pkg.
module wvp_vector import wvp_pkg::*; #(
   parameter int STAGES = 24,
   parameter int SIDE_W = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 in_valid,
   input  logic signed [XW-1:0] in_x,
   input  logic signed [XW-1:0] in_y,
   input  logic [SIDE_W-1:0]    in_side,
   output logic                 out_valid,
   output logic signed [AW-1:0] out_ang,
   output logic signed [XW-1:0] out_mag,
   output logic [SIDE_W-1:0]    out_side
);

   logic signed [AW-1:0] atan_c [STAGES];
   logic signed [XW-1:0] x_in;
   logic signed [XW-1:0] y_in;
   logic signed [AW-1:0] z_in;
   logic                 zero_in;
   logic [STAGES:0]      valid_ff;
   logic [STAGES:0]      zero_ff;
   logic [SIDE_W-1:0]    side_ff [STAGES+1];
   logic signed [XW-1:0] x_ff [STAGES+1];
   logic signed [XW-1:0] y_ff [STAGES+1];
   logic signed [AW-1:0] z_ff [STAGES+1];

   for (genvar g = 0; g < STAGES; g++) begin : g_atan
      assign atan_c[g] = atan_rom(g);
   end

   // A vector in the left half plane is first turned by a quarter turn.
   always_comb begin
      zero_in = (in_x == '0) && (in_y == '0);
      x_in = in_x;
      y_in = in_y;
      z_in = '0;
      if (in_x < 0) begin
         if (in_y >= 0) begin
            x_in = in_y;
            y_in = -in_x;
            z_in = Q29_HALF_PI;
         end else begin
            x_in = -in_y;
            y_in = in_x;
            z_in = -Q29_HALF_PI;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[STAGES-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= in_side;
         zero_ff    <= {zero_ff[STAGES-1:0], zero_in};
         x_ff[0]    <= x_in;
         y_ff[0]    <= y_in;
         z_ff[0]    <= z_in;
         for (int s = 0; s < STAGES; s++) begin
            side_ff[s+1] <= side_ff[s];
            if (y_ff[s] >= 0) begin
               x_ff[s+1] <= x_ff[s] + (y_ff[s] >>> s);
               y_ff[s+1] <= y_ff[s] - (x_ff[s] >>> s);
               z_ff[s+1] <= z_ff[s] + atan_c[s];
            end else begin
               x_ff[s+1] <= x_ff[s] - (y_ff[s] >>> s);
               y_ff[s+1] <= y_ff[s] + (x_ff[s] >>> s);
               z_ff[s+1] <= z_ff[s] - atan_c[s];
            end
         end
      end
   end

   assign out_valid = valid_ff[STAGES];
   assign out_ang   = zero_ff[STAGES] ? '0 : z_ff[STAGES];
   assign out_mag   = x_ff[STAGES];
   assign out_side  = side_ff[STAGES];

endmodule

// ===== design/waypoint_view_projection_unit.sv =====
// Top level of the waypoint view projection: offsets, bearing, distance, elevation, roll.
// Depends on wvp_pkg, wvp_ifs, wvp_rotate, wvp_vector and assert_macros.svh.
//
//   channel   dir  handshake      word
//   req_if    in   valid/ready    waypoint, own position, attitude, tag
//   rsp_if    out  valid/ready    screen_x, screen_y, tag_out
//
// One word is taken every cycle while no result waits unaccepted; the sine/cosine, bearing
// and elevation CORDIC pipelines lie in series.
// Reset clears all valid bits; payload registers are not reset.
// The whole pipeline advances together and holds when a result waits unaccepted.
`include "assert_macros.svh"

module waypoint_view_projection_unit import wvp_pkg::*; #(
   parameter int CORDIC_STAGES = 24
) (
   input logic       clock,
   input logic       reset,
   wvp_req_if.sink   req_if,
   wvp_rsp_if.source rsp_if
);

   localparam logic signed [AW-1:0] BEARING_MAX = 34'sd1800000000;

   logic                 adv;
   rot_side_type         rot_side_in;
   rot_side_type         rot_side_out;
   logic signed [31:0]   rot_angle [ROT_LANES];
   logic signed [CW-1:0] rot_cos [ROT_LANES];
   logic signed [CW-1:0] rot_sin [ROT_LANES];
   logic                 rot_valid;

   logic                 d_valid_ff;
   logic signed [XW-1:0] dlat_ff;
   logic signed [66:0]   dlon_prod_ff;
   vec_side_type         d_side_ff;

   logic                 v1_valid;
   logic signed [AW-1:0] v1_ang;
   logic signed [XW-1:0] v1_mag;
   vec_side_type         v1_side;

   logic [3:0]           m_valid_ff;
   mid_type              mid_ff [4];
   logic [61:0]          p_hi_ff;
   logic [59:0]          p_lo_ff;
   logic [43:0]          m_ff;
   logic [56:0]          a1_ff;
   logic [52:0]          a2_ff;
   logic [XW-1:0]        dist_ff;

   elev_side_type        v2_side_in;
   elev_side_type        v2_side;
   logic                 v2_valid;
   logic signed [AW-1:0] v2_ang;
   logic signed [AW-1:0] elev;

   logic [1:0]           f_valid_ff;
   logic signed [AW-1:0] h_ff;
   logic signed [AW-1:0] v_ff;
   logic signed [CW-1:0] cr_ff;
   logic signed [CW-1:0] sr_ff;
   logic [15:0]          tag1_ff;
   logic signed [PW-1:0] hc_ff;
   logic signed [PW-1:0] hs_ff;
   logic signed [PW-1:0] vc_ff;
   logic signed [PW-1:0] vs_ff;
   logic [15:0]          tag2_ff;
   logic signed [PW:0]   sx;
   logic signed [PW:0]   sy;
   logic signed [PW:0]   rx;
   logic signed [PW:0]   ry;
   logic signed [31:0]   x_in;
   logic signed [31:0]   y_in;
   logic                 f3_valid_ff;
   logic signed [31:0]   x_ff;
   logic signed [31:0]   y_ff;
   logic [15:0]          tag_ff;

   assign adv          = !f3_valid_ff || rsp_if.ready;
   assign req_if.ready = adv;

   always_comb begin
      rot_angle[0]       = 32'(req_if.own_lat);
      rot_angle[1]       = req_if.roll_angle;
      rot_side_in.dlat_d = 32'(req_if.waypoint_lat) - 32'(req_if.own_lat);
      rot_side_in.dlon_d = 33'(req_if.waypoint_lon) - 33'(req_if.own_lon);
      rot_side_in.dalt_d = 33'(req_if.waypoint_alt) - 33'(req_if.own_alt);
      rot_side_in.yaw    = req_if.yaw_angle;
      rot_side_in.pitch  = req_if.pitch_angle;
      rot_side_in.tag    = req_if.waypoint_tag;
   end

   wvp_rotate #(
      .STAGES (CORDIC_STAGES),
      .SIDE_W ($bits(rot_side_type))
   ) u_rotate (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_if.valid),
      .in_angle  (rot_angle),
      .in_side   (rot_side_in),
      .out_valid (rot_valid),
      .out_cos   (rot_cos),
      .out_sin   (rot_sin),
      .out_side  (rot_side_out)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         dlat_ff            <= XW'($signed(rot_side_out.dlat_d)) <<< 24;
         dlon_prod_ff       <= 67'($signed(rot_side_out.dlon_d)) * 67'(rot_cos[0]);
         d_side_ff.cos_roll <= rot_cos[1];
         d_side_ff.sin_roll <= rot_sin[1];
         d_side_ff.dalt_d   <= rot_side_out.dalt_d;
         d_side_ff.yaw      <= rot_side_out.yaw;
         d_side_ff.pitch    <= rot_side_out.pitch;
         d_side_ff.tag      <= rot_side_out.tag;
      end
   end

   wvp_vector #(
      .STAGES (CORDIC_STAGES),
      .SIDE_W ($bits(vec_side_type))
   ) u_bearing (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (d_valid_ff),
      .in_x      (dlat_ff),
      .in_y      (XW'(dlon_prod_ff >>> 6)),
      .in_side   (d_side_ff),
      .out_valid (v1_valid),
      .out_ang   (v1_ang),
      .out_mag   (v1_mag),
      .out_side  (v1_side)
   );

   // Magnitude gain correction, then scaling by the earth radius into mm Q16.
   always_ff @(posedge clock) begin
      if (adv) begin
         mid_ff[0].bearing <= v1_ang;
         mid_ff[0].base    <= v1_side;
         for (int k = 0; k < 3; k++) begin
            mid_ff[k+1] <= mid_ff[k];
         end
         p_hi_ff <= 62'(v1_mag[XW-1:30]) * 62'(Q30_GAIN_U);
         p_lo_ff <= 60'(v1_mag[29:0]) * 60'(Q30_GAIN_U);
         m_ff    <= 44'((p_hi_ff + 62'(p_lo_ff >> 30)) >> 16);
         a1_ff   <= 57'(m_ff[43:20]) * 57'(EARTH_RADIUS_MM);
         a2_ff   <= 53'(m_ff[19:0]) * 53'(EARTH_RADIUS_MM);
         dist_ff <= XW'((58'(a1_ff) + 58'(a2_ff >> 20)) >> 1);
      end
   end

   always_comb begin
      v2_side_in.bearing   = mid_ff[3].bearing;
      v2_side_in.cos_roll  = mid_ff[3].base.cos_roll;
      v2_side_in.sin_roll  = mid_ff[3].base.sin_roll;
      v2_side_in.yaw       = mid_ff[3].base.yaw;
      v2_side_in.pitch     = mid_ff[3].base.pitch;
      v2_side_in.tag       = mid_ff[3].base.tag;
      v2_side_in.dist_zero = (dist_ff == '0);
      v2_side_in.dalt_pos  = $signed(mid_ff[3].base.dalt_d) > 0;
      v2_side_in.dalt_neg  = $signed(mid_ff[3].base.dalt_d) < 0;
   end

   wvp_vector #(
      .STAGES (CORDIC_STAGES),
      .SIDE_W ($bits(elev_side_type))
   ) u_elevation (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (m_valid_ff[3]),
      .in_x      ($signed(dist_ff)),
      .in_y      (XW'($signed(mid_ff[3].base.dalt_d)) <<< 16),
      .in_side   (v2_side_in),
      .out_valid (v2_valid),
      .out_ang   (v2_ang),
      .out_mag   (),
      .out_side  (v2_side)
   );

   // With no ground distance the elevation is straight up, straight down or level.
   always_comb begin
      elev = v2_ang;
      if (v2_side.dist_zero) begin
         if (v2_side.dalt_pos) begin
            elev = Q29_HALF_PI;
         end else if (v2_side.dalt_neg) begin
            elev = -Q29_HALF_PI;
         end else begin
            elev = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         h_ff    <= $signed(v2_side.bearing) - AW'($signed(v2_side.yaw));
         v_ff    <= elev - AW'($signed(v2_side.pitch));
         cr_ff   <= v2_side.cos_roll;
         sr_ff   <= v2_side.sin_roll;
         tag1_ff <= v2_side.tag;
         hc_ff   <= PW'((68'(h_ff) * 68'(cr_ff)) >>> 30);
         hs_ff   <= PW'((68'(h_ff) * 68'(sr_ff)) >>> 30);
         vc_ff   <= PW'((68'(v_ff) * 68'(cr_ff)) >>> 30);
         vs_ff   <= PW'((68'(v_ff) * 68'(sr_ff)) >>> 30);
         tag2_ff <= tag1_ff;
         x_ff    <= x_in;
         y_ff    <= y_in;
         tag_ff  <= tag2_ff;
      end
   end

   // Round Q29 to Q26 and clamp to the 32-bit range.
   always_comb begin
      sx = (PW+1)'(hc_ff) - (PW+1)'(vs_ff);
      sy = (PW+1)'(hs_ff) - (PW+1)'(vc_ff);
      rx = (sx + 4) >>> 3;
      ry = (sy + 4) >>> 3;
      x_in = rx[31:0];
      y_in = ry[31:0];
      if (rx > (PW+1)'(32'sh7fffffff)) begin
         x_in = 32'sh7fffffff;
      end else if (rx < -(PW+1)'(33'sh080000000)) begin
         x_in = 32'sh80000000;
      end
      if (ry > (PW+1)'(32'sh7fffffff)) begin
         y_in = 32'sh7fffffff;
      end else if (ry < -(PW+1)'(33'sh080000000)) begin
         y_in = 32'sh80000000;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff  <= 1'b0;
         m_valid_ff  <= '0;
         f_valid_ff  <= '0;
         f3_valid_ff <= 1'b0;
      end else if (adv) begin
         d_valid_ff  <= rot_valid;
         m_valid_ff  <= {m_valid_ff[2:0], v1_valid};
         f_valid_ff  <= {f_valid_ff[0], v2_valid};
         f3_valid_ff <= f_valid_ff[1];
      end
   end

   assign rsp_if.valid    = f3_valid_ff;
   assign rsp_if.screen_x = x_ff;
   assign rsp_if.screen_y = y_ff;
   assign rsp_if.tag_out  = tag_ff;

   `ASSERT_NEXT(a_stall_holds_mid, clock, reset, !adv, $stable(m_valid_ff), "pipeline moved in stall")
   `ASSERT_IMPLIES(a_dist_nonneg, clock, reset, m_valid_ff[3], !dist_ff[XW-1], "distance negative")
   `ASSERT_IMPLIES(a_bearing_range, clock, reset, m_valid_ff[0], (($signed(mid_ff[0].bearing) <= BEARING_MAX) && ($signed(mid_ff[0].bearing) >= -BEARING_MAX)), "bearing out of range")

endmodule
